// ===== hdl/hough_lane_classify_average_top_defines.svh =====
// Assertion macros shared by the checker files of the lane averager.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HOUGH_LANE_CLASSIFY_AVERAGE_TOP_DEFINES_SVH
`define HOUGH_LANE_CLASSIFY_AVERAGE_TOP_DEFINES_SVH

// cond must never hold outside reset
`define HLCA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// when ante holds, cons must hold in the next cycle
`define HLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hlca_pkg.sv =====
// Package of the Hough lane averager: state codes, register indexes,
// CORDIC constants and the arctangent table. No dependencies.
package hlca_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_PT,
        ST_DIFF,
        ST_WIN,
        ST_ACC,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_DONE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        CFG_HALF_LENGTH  = 3'd0,
        CFG_LEFT_LOW     = 3'd1,
        CFG_LEFT_HIGH    = 3'd2,
        CFG_RIGHT_LOW    = 3'd3,
        CFG_RIGHT_HIGH   = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [11:0]        RST_HALF_LENGTH = 12'd1500;
    localparam logic signed [15:0] RST_LEFT_LOW    = -16'sd192;
    localparam logic signed [15:0] RST_LEFT_HIGH   = -16'sd166;
    localparam logic signed [15:0] RST_RIGHT_LOW   = 16'sd205;
    localparam logic signed [15:0] RST_RIGHT_HIGH  = 16'sd340;

    localparam int CORDIC_ITERS = 20;
    localparam int CORDIC_W     = 33;
    localparam int ZW           = 26;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // arctangent of 2^-i in units of pi/2^24
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                5'd0:    v = 26'sd4194304;
                5'd1:    v = 26'sd2476042;
                5'd2:    v = 26'sd1308273;
                5'd3:    v = 26'sd664100;
                5'd4:    v = 26'sd333339;
                5'd5:    v = 26'sd166832;
                5'd6:    v = 26'sd83436;
                5'd7:    v = 26'sd41721;
                5'd8:    v = 26'sd20861;
                5'd9:    v = 26'sd10430;
                5'd10:   v = 26'sd5215;
                5'd11:   v = 26'sd2608;
                5'd12:   v = 26'sd1304;
                5'd13:   v = 26'sd652;
                5'd14:   v = 26'sd326;
                5'd15:   v = 26'sd163;
                5'd16:   v = 26'sd81;
                5'd17:   v = 26'sd41;
                5'd18:   v = 26'sd20;
                5'd19:   v = 26'sd10;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hdl/hlca_if.sv =====
// Channel interfaces of the Hough lane averager: line words in, lane
// result words out. Valid/ready handshake. No dependencies.
interface hlca_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] rho;
    logic [15:0]        theta;
    logic               line_valid;
    logic               frame_end;

    modport source (output valid, rho, theta, line_valid, frame_end, input ready);
    modport sink   (input valid, rho, theta, line_valid, frame_end, output ready);
endinterface

interface hlca_out_if #(
    parameter int COORD_BITS = 14
);
    logic                         valid;
    logic                         ready;
    logic                         side;
    logic                         found;
    logic signed [COORD_BITS-1:0] avg_x1;
    logic signed [COORD_BITS-1:0] avg_y1;
    logic signed [COORD_BITS-1:0] avg_x2;
    logic signed [COORD_BITS-1:0] avg_y2;
    logic [10:0]                  line_count;
    logic                         overflow;
    logic                         last_result;

    modport source (output valid, side, found, avg_x1, avg_y1, avg_x2, avg_y2,
                    line_count, overflow, last_result, input ready);
    modport sink   (input valid, side, found, avg_x1, avg_y1, avg_x2, avg_y2,
                    line_count, overflow, last_result, output ready);
endinterface

// ===== hdl/hough_lane_classify_average_top.sv =====
// Hough lane classifier and averager: CORDIC, endpoint, slope window,
// accumulation and averaging divider under one sequencer.
// Depends on hlca_pkg and hlca_if.
//
//  channel  | dir | words
//  ---------+-----+----------------------------------------------
//  in_ch    | in  | one Hough line and/or frame end per word
//  out_ch   | out | two lane averages per frame end, left then right
//  cfg_*    | in  | register writes, taken at any edge with cfg_we
//
// A line word holds the block through 20 CORDIC rotations, then the
// multiply, endpoint, difference, window and accumulate steps through the one
// shared multiplier and adder; a new word is taken only once the last is done.
// A frame end adds, per side with lines, 4 averages on the bit-serial divider,
// per empty side only the setup steps, plus the output handshake.
// in_ch.ready is high only between words.
// A stalled out_ch holds the block. Reset clears all sums and restores the
// register defaults at once; there is no clearing pass.
module hough_lane_classify_average_top #(
    parameter int MAX_LINES  = 1024,
    parameter int COORD_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    hlca_in_if.sink                             in_ch,
    hlca_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [hlca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hlca_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW     = hlca_pkg::CORDIC_W;
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int SUM_W  = COORD_BITS + CNT_W;
    localparam int MB_W   = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;
    localparam int P_W    = CW + MB_W;
    localparam int E_W    = P_W + 5;
    localparam int PX_W   = E_W - 34;
    localparam int NUM_W  = SUM_W + 3;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int DC_W   = $clog2(NUM_W + 1);
    localparam int D_W    = COORD_BITS + 1;

    localparam logic signed [E_W-1:0]  RND    = E_W'(64'sd1 <<< 33);
    localparam logic signed [PX_W-1:0] PIX_HI = PX_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [PX_W-1:0] PIX_LO = PX_W'(-(64'sd1 <<< (COORD_BITS - 1)));

    // configuration
    logic [11:0]        half_length_reg;
    logic signed [15:0] left_low_reg, left_high_reg, right_low_reg, right_high_reg;

    hlca_pkg::state_t state_reg, state_next;

    logic signed [16:0]           rho_reg;
    logic                         upper_reg;
    logic                         fend_reg;
    logic signed [CW-1:0]         x_reg, y_reg;
    logic signed [hlca_pkg::ZW-1:0] z_reg;
    logic [4:0]                   iter_reg;
    logic [2:0]                   step_reg;
    logic signed [P_W-1:0]        prod_reg;
    logic signed [E_W-1:0]        x0_reg, y0_reg, hs_reg, hc_reg;
    logic signed [COORD_BITS-1:0] pt_reg [4];
    logic signed [D_W-1:0]        dx_reg, dy_reg;
    logic [3:0]                   win_reg;

    logic signed [SUM_W-1:0]      lsum_reg [4];
    logic signed [SUM_W-1:0]      rsum_reg [4];
    logic [CNT_W-1:0]             lcnt_reg, rcnt_reg;
    logic                         lovf_reg, rovf_reg;

    logic                         side_reg;
    logic [1:0]                   k_reg;
    logic [NUM_W-1:0]             dq_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [DEN_W-1:0]             den_reg;
    logic                         neg_reg;
    logic [DC_W-1:0]              dcnt_reg;
    logic signed [COORD_BITS-1:0] avg_reg [4];

    // ------------------------------------------------------------------
    // combinational datapath
    logic                         in_acc, out_acc;
    logic signed [CW-1:0]         c_val, s_val, xsh, ysh;
    logic signed [hlca_pkg::ZW-1:0] atan_v;
    logic signed [CW-1:0]         mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [P_W-1:0]        prod;
    logic signed [MB_W-1:0]       hl_ext;
    logic signed [E_W-1:0]        ep_v, ep_r, ep_s;
    logic signed [PX_W-1:0]       pxw;
    logic signed [COORD_BITS-1:0] pix;
    logic signed [P_W-1:0]        nn;
    logic [1:0]                   widx;
    logic                         dpos, win_ok;
    logic                         go_left, go_right;
    logic signed [SUM_W-1:0]      sum_sel;
    logic [CNT_W-1:0]             cnt_sel;
    logic                         ovf_sel;
    logic signed [NUM_W-1:0]      num;
    logic [DEN_W-1:0]             den;
    logic [NUM_W-1:0]             mag;
    logic [REM_W-1:0]             trial;
    logic                         qbit;
    logic [NUM_W-1:0]             qneg;
    logic [CNT_W+10:0]            cnt_ext;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    assign c_val  = upper_reg ? -y_reg : x_reg;
    assign s_val  = upper_reg ? x_reg : y_reg;
    assign xsh    = x_reg >>> iter_reg;
    assign ysh    = y_reg >>> iter_reg;
    assign atan_v = hlca_pkg::atan_lut(iter_reg);
    assign hl_ext = MB_W'($signed({1'b0, half_length_reg}));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == hlca_pkg::ST_MUL)
        begin
            case (step_reg[1:0])
                2'd0:    begin mul_a = c_val; mul_b = MB_W'(rho_reg); end
                2'd1:    begin mul_a = s_val; mul_b = MB_W'(rho_reg); end
                2'd2:    begin mul_a = s_val; mul_b = hl_ext; end
                default: begin mul_a = c_val; mul_b = hl_ext; end
            endcase
        end
        else if (state_reg == hlca_pkg::ST_WIN)
        begin
            mul_b = MB_W'(dx_reg);
            case (step_reg[1:0])
                2'd0:    mul_a = CW'(left_low_reg);
                2'd1:    mul_a = CW'(left_high_reg);
                2'd2:    mul_a = CW'(right_low_reg);
                default: mul_a = CW'(right_high_reg);
            endcase
        end
    end

    assign prod = P_W'(mul_a) * P_W'(mul_b);

    // endpoint in Q34, rounded half up and clamped to pixels
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    ep_v = x0_reg - hs_reg;
            2'd1:    ep_v = y0_reg + hc_reg;
            2'd2:    ep_v = x0_reg + hs_reg;
            default: ep_v = y0_reg - hc_reg;
        endcase
        ep_r = ep_v + RND;
        ep_s = ep_r >>> 34;
        pxw  = ep_s[PX_W-1:0];
        if (pxw > PIX_HI)
            pix = PIX_HI[COORD_BITS-1:0];
        else if (pxw < PIX_LO)
            pix = PIX_LO[COORD_BITS-1:0];
        else
            pix = pxw[COORD_BITS-1:0];
    end

    // slope window compare on the registered product
    assign nn   = P_W'(dy_reg) <<< 8;
    assign widx = 2'(step_reg - 3'd1);
    assign dpos = dx_reg > 0;
    always_comb
    begin
        if (!widx[0])
            win_ok = dpos ? (prod_reg <= nn) : (prod_reg >= nn);
        else
            win_ok = dpos ? (prod_reg >= nn) : (prod_reg <= nn);
    end

    assign go_left  = (dx_reg != '0) && win_reg[0] && win_reg[1];
    assign go_right = (dx_reg != '0) && win_reg[2] && win_reg[3] && !go_left;

    // averaging divider operands
    assign sum_sel = side_reg ? rsum_reg[k_reg] : lsum_reg[k_reg];
    assign cnt_sel = side_reg ? rcnt_reg : lcnt_reg;
    assign ovf_sel = side_reg ? rovf_reg : lovf_reg;
    assign num     = (NUM_W'(sum_sel) <<< 1) + $signed(NUM_W'(cnt_sel));
    assign den     = {cnt_sel, 1'b0};
    assign mag     = num[NUM_W-1] ? NUM_W'(-num + $signed(NUM_W'(den)) - 1) : NUM_W'(num);
    assign trial   = {rem_reg[REM_W-2:0], dq_reg[NUM_W-1]};
    assign qbit    = trial >= REM_W'(den_reg);
    assign qneg    = neg_reg ? (~dq_reg + 1'b1) : dq_reg;

    // ------------------------------------------------------------------
    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hlca_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hlca_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.line_valid)
                        state_next = hlca_pkg::ST_CORDIC;
                    else if (in_ch.frame_end)
                        state_next = hlca_pkg::ST_DIV_SETUP;
                end
            end
            hlca_pkg::ST_CORDIC:
                if (iter_reg == 5'(hlca_pkg::CORDIC_ITERS - 1))
                    state_next = hlca_pkg::ST_MUL;
            hlca_pkg::ST_MUL:
                if (step_reg == 3'd4)
                    state_next = hlca_pkg::ST_PT;
            hlca_pkg::ST_PT:
                if (step_reg == 3'd3)
                    state_next = hlca_pkg::ST_DIFF;
            hlca_pkg::ST_DIFF:
                state_next = hlca_pkg::ST_WIN;
            hlca_pkg::ST_WIN:
                if (step_reg == 3'd4)
                    state_next = hlca_pkg::ST_ACC;
            hlca_pkg::ST_ACC:
                state_next = fend_reg ? hlca_pkg::ST_DIV_SETUP : hlca_pkg::ST_IDLE;
            hlca_pkg::ST_DIV_SETUP:
            begin
                if (cnt_sel != '0)
                    state_next = hlca_pkg::ST_DIV;
                else if (k_reg == 2'd3)
                    state_next = hlca_pkg::ST_OUT;
            end
            hlca_pkg::ST_DIV:
                if (dcnt_reg == DC_W'(NUM_W - 1))
                    state_next = hlca_pkg::ST_DIV_DONE;
            hlca_pkg::ST_DIV_DONE:
                state_next = (k_reg == 2'd3) ? hlca_pkg::ST_OUT : hlca_pkg::ST_DIV_SETUP;
            hlca_pkg::ST_OUT:
                if (out_acc)
                    state_next = side_reg ? hlca_pkg::ST_IDLE : hlca_pkg::ST_DIV_SETUP;
            default:
                state_next = hlca_pkg::ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= hlca_pkg::RST_HALF_LENGTH;
            left_low_reg    <= hlca_pkg::RST_LEFT_LOW;
            left_high_reg   <= hlca_pkg::RST_LEFT_HIGH;
            right_low_reg   <= hlca_pkg::RST_RIGHT_LOW;
            right_high_reg  <= hlca_pkg::RST_RIGHT_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hlca_pkg::CFG_HALF_LENGTH: half_length_reg <= cfg_data[11:0];
                hlca_pkg::CFG_LEFT_LOW:    left_low_reg    <= cfg_data;
                hlca_pkg::CFG_LEFT_HIGH:   left_high_reg   <= cfg_data;
                hlca_pkg::CFG_RIGHT_LOW:   right_low_reg   <= cfg_data;
                hlca_pkg::CFG_RIGHT_HIGH:  right_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-side accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lsum_reg[i] <= '0;
                rsum_reg[i] <= '0;
            end
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            lovf_reg <= 1'b0;
            rovf_reg <= 1'b0;
        end
        else if (state_reg == hlca_pkg::ST_ACC)
        begin
            if (go_left)
            begin
                if (lcnt_reg >= CNT_W'(MAX_LINES))
                    lovf_reg <= 1'b1;
                else
                begin
                    for (int i = 0; i < 4; i++)
                        lsum_reg[i] <= lsum_reg[i] + SUM_W'(pt_reg[i]);
                    lcnt_reg <= lcnt_reg + 1'b1;
                end
            end
            else if (go_right)
            begin
                if (rcnt_reg >= CNT_W'(MAX_LINES))
                    rovf_reg <= 1'b1;
                else
                begin
                    for (int i = 0; i < 4; i++)
                        rsum_reg[i] <= rsum_reg[i] + SUM_W'(pt_reg[i]);
                    rcnt_reg <= rcnt_reg + 1'b1;
                end
            end
        end
        else if (state_reg == hlca_pkg::ST_OUT && out_acc && side_reg)
        begin
            // frame done: drop all sums
            for (int i = 0; i < 4; i++)
            begin
                lsum_reg[i] <= '0;
                rsum_reg[i] <= '0;
            end
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            lovf_reg <= 1'b0;
            rovf_reg <= 1'b0;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            step_reg <= '0;
            dcnt_reg <= '0;
            k_reg    <= '0;
            side_reg <= 1'b0;
            fend_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                hlca_pkg::ST_IDLE:
                begin
                    iter_reg <= '0;
                    step_reg <= '0;
                    k_reg    <= '0;
                    side_reg <= 1'b0;
                    if (in_acc)
                        fend_reg <= in_ch.frame_end;
                end
                hlca_pkg::ST_CORDIC:
                    iter_reg <= iter_reg + 1'b1;
                hlca_pkg::ST_MUL, hlca_pkg::ST_WIN:
                    step_reg <= (step_reg == 3'd4) ? 3'd0 : step_reg + 1'b1;
                hlca_pkg::ST_PT:
                    step_reg <= (step_reg == 3'd3) ? 3'd0 : step_reg + 1'b1;
                hlca_pkg::ST_DIV_SETUP:
                begin
                    dcnt_reg <= '0;
                    if (cnt_sel == '0)
                        k_reg <= k_reg + 1'b1;
                end
                hlca_pkg::ST_DIV:
                    dcnt_reg <= dcnt_reg + 1'b1;
                hlca_pkg::ST_DIV_DONE:
                    k_reg <= k_reg + 1'b1;
                hlca_pkg::ST_OUT:
                begin
                    if (out_acc)
                    begin
                        side_reg <= 1'b1;
                        k_reg    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            hlca_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    rho_reg   <= in_ch.rho;
                    upper_reg <= in_ch.theta[15];
                    x_reg     <= hlca_pkg::CORDIC_GAIN;
                    y_reg     <= '0;
                    z_reg     <= hlca_pkg::ZW'({in_ch.theta[14:0], 8'd0});
                end
            end
            hlca_pkg::ST_CORDIC:
            begin
                if (!z_reg[hlca_pkg::ZW-1])
                begin
                    x_reg <= x_reg - ysh;
                    y_reg <= y_reg + xsh;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + ysh;
                    y_reg <= y_reg - xsh;
                    z_reg <= z_reg + atan_v;
                end
            end
            hlca_pkg::ST_MUL:
            begin
                prod_reg <= prod;
                case (step_reg)
                    3'd1:    x0_reg <= E_W'(prod_reg);
                    3'd2:    y0_reg <= E_W'(prod_reg);
                    3'd3:    hs_reg <= E_W'(prod_reg) <<< 4;
                    3'd4:    hc_reg <= E_W'(prod_reg) <<< 4;
                    default: ;
                endcase
            end
            hlca_pkg::ST_PT:
                pt_reg[step_reg[1:0]] <= pix;
            hlca_pkg::ST_DIFF:
            begin
                dx_reg <= D_W'(pt_reg[2]) - D_W'(pt_reg[0]);
                dy_reg <= D_W'(pt_reg[3]) - D_W'(pt_reg[1]);
            end
            hlca_pkg::ST_WIN:
            begin
                prod_reg <= prod;
                if (step_reg != 3'd0)
                    win_reg[widx] <= win_ok;
            end
            hlca_pkg::ST_DIV_SETUP:
            begin
                if (cnt_sel == '0)
                    avg_reg[k_reg] <= '0;
                dq_reg  <= mag;
                rem_reg <= '0;
                den_reg <= den;
                neg_reg <= num[NUM_W-1];
            end
            hlca_pkg::ST_DIV:
            begin
                rem_reg <= qbit ? (trial - REM_W'(den_reg)) : trial;
                dq_reg  <= {dq_reg[NUM_W-2:0], qbit};
            end
            hlca_pkg::ST_DIV_DONE:
                avg_reg[k_reg] <= qneg[COORD_BITS-1:0];
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // channel ports
    assign cnt_ext = (CNT_W + 11)'(cnt_sel);

    assign in_ch.ready        = (state_reg == hlca_pkg::ST_IDLE);
    assign out_ch.valid       = (state_reg == hlca_pkg::ST_OUT);
    assign out_ch.side        = side_reg;
    assign out_ch.found       = (cnt_sel != '0);
    assign out_ch.avg_x1      = avg_reg[0];
    assign out_ch.avg_y1      = avg_reg[1];
    assign out_ch.avg_x2      = avg_reg[2];
    assign out_ch.avg_y2      = avg_reg[3];
    assign out_ch.line_count  = cnt_ext[10:0];
    assign out_ch.overflow    = ovf_sel;
    assign out_ch.last_result = side_reg;

endmodule

// ===== hdl/hlca_check.sv =====
// Port-level checker for the Hough lane averager, bound to the top level.
// Depends on hough_lane_classify_average_top_defines.svh.
`include "hough_lane_classify_average_top_defines.svh"

module hlca_check (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic side,
    input logic last_result
);

    // the block never takes a line word while a result word waits
    `HLCA_ASSERT_NEVER(a_busy_excl, in_ready && out_valid, "input ready while result pending")

    `HLCA_ASSERT_NEVER(a_last_side, out_valid && (last_result != side), "last_result not on right word")

    `HLCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

    // each result word is computed afresh, never shown twice in a row
    `HLCA_ASSERT_NEXT(a_word_gap, out_valid && out_ready, !out_valid, "result word repeated")

    // after the left word the block stays busy for the right one
    `HLCA_ASSERT_NEXT(a_side_pair, out_valid && out_ready && !side, !in_ready, "right word skipped")

endmodule

bind hough_lane_classify_average_top hlca_check u_hlca_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .side        (out_ch.side),
    .last_result (out_ch.last_result)
);

// ===== tb/sv/tb_hough_lane_classify_average_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the Hough lane classifier and averager: random and
// directed line words, lane averages predicted in-bench and checked per field.
// Depends on hlca_pkg, hlca_if and hough_lane_classify_average_top.
module tb_hough_lane_classify_average_top;

    localparam int  MAX_LINES   = 1024;
    localparam int  COORD_BITS  = 14;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  LEFT_THETA  = 19700;  // cot ~0.72, inside the default left window
    localparam int  RIGHT_THETA = 49000;  // cot ~-0.99, inside the default right window

    typedef struct {
        logic signed [16:0] rho;
        logic [15:0]        theta;
        logic               line_valid;
        logic               frame_end;
    } line_word_t;

    typedef struct {
        logic                         side;
        logic                         found;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic [10:0]                  line_count;
        logic                         overflow;
        logic                         last_result;
    } lane_avg_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [hlca_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hlca_pkg::CFG_DATA_W-1:0] cfg_data;

    hlca_in_if                            in_ch ();
    hlca_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

    hough_lane_classify_average_top #(
        .MAX_LINES  (MAX_LINES),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_word_t word_q[$];
    lane_avg_t  lane_avg_q[$];
    int         errors;
    int         words_taken;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_left;
    bit         hold_done;
    longint     cycles;

    // bench copy of the block state and registers
    longint     seg_half;
    longint     lo_left, hi_left, lo_right, hi_right;
    longint     left_sum[4], right_sum[4];
    int         left_n, right_n;
    bit         left_ovf, right_ovf;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void rotate(input logic [15:0] t, output longint c, output longint s);
        longint x, y, z, dx, dy;
        longint atan_v[20];
        bit     upper;
        atan_v = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
                   20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10};
        upper = t[15];
        z = longint'(t[14:0]) << 8;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_v[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_v[i];
            end
        end
        if (upper)
        begin
            c = -y; s = x;
        end
        else
        begin
            c = x; s = y;
        end
    endfunction

    function automatic longint round_pixel(input longint q34);
        longint p;
        p = (q34 + (longint'(1) << 33)) >>> 34;
        if (p > 8191)
            p = 8191;
        if (p < -8192)
            p = -8192;
        return p;
    endfunction

    function automatic bit slope_in(input longint dx, input longint dy,
                                    input longint lo, input longint hi);
        longint n;
        n = dy * 256;
        if (dx > 0)
            return (lo * dx <= n) && (n <= hi * dx);
        if (dx < 0)
            return (lo * dx >= n) && (n >= hi * dx);
        return 1'b0;
    endfunction

    function automatic longint avg_nearest(input longint sum, input int n);
        longint num, den;
        num = 2 * sum + n;
        den = 2 * n;
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic lane_avg_t lane_result(input bit side, input longint sums[4],
                                              input int n, input bit ovf);
        lane_avg_t r;
        longint    a[4];
        for (int k = 0; k < 4; k++)
            a[k] = (n != 0) ? avg_nearest(sums[k], n) : 0;
        r.side        = side;
        r.found       = (n != 0);
        r.x1          = a[0][COORD_BITS-1:0];
        r.y1          = a[1][COORD_BITS-1:0];
        r.x2          = a[2][COORD_BITS-1:0];
        r.y2          = a[3][COORD_BITS-1:0];
        r.line_count  = n[10:0];
        r.overflow    = ovf;
        r.last_result = side;
        return r;
    endfunction

    function automatic void predict_lanes(input line_word_t w);
        longint c, s, r, x0, y0, hs, hc, pt[4], dx, dy;
        if (w.line_valid)
        begin
            rotate(w.theta, c, s);
            r  = w.rho;
            x0 = c * r;
            y0 = s * r;
            hs = seg_half * s * 16;
            hc = seg_half * c * 16;
            pt[0] = round_pixel(x0 - hs);
            pt[1] = round_pixel(y0 + hc);
            pt[2] = round_pixel(x0 + hs);
            pt[3] = round_pixel(y0 - hc);
            dx = pt[2] - pt[0];
            dy = pt[3] - pt[1];
            if (slope_in(dx, dy, lo_left, hi_left))
            begin
                if (left_n >= MAX_LINES)
                    left_ovf = 1'b1;
                else
                begin
                    for (int k = 0; k < 4; k++)
                        left_sum[k] += pt[k];
                    left_n++;
                end
            end
            else if (slope_in(dx, dy, lo_right, hi_right))
            begin
                if (right_n >= MAX_LINES)
                    right_ovf = 1'b1;
                else
                begin
                    for (int k = 0; k < 4; k++)
                        right_sum[k] += pt[k];
                    right_n++;
                end
            end
        end
        if (w.frame_end)
        begin
            lane_avg_q.insert(lane_avg_q.size(),
                              lane_result(1'b0, left_sum, left_n, left_ovf));
            lane_avg_q.insert(lane_avg_q.size(),
                              lane_result(1'b1, right_sum, right_n, right_ovf));
            for (int k = 0; k < 4; k++)
            begin
                left_sum[k]  = 0;
                right_sum[k] = 0;
            end
            left_n    = 0;
            right_n   = 0;
            left_ovf  = 1'b0;
            right_ovf = 1'b0;
        end
    endfunction

    // driver: predict on each accepted word, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        line_word_t w;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.rho        <= '0;
            in_ch.theta      <= '0;
            in_ch.line_valid <= 1'b0;
            in_ch.frame_end  <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                w.rho        = in_ch.rho;
                w.theta      = in_ch.theta;
                w.line_valid = in_ch.line_valid;
                w.frame_end  = in_ch.frame_end;
                predict_lanes(w);
                words_taken <= words_taken + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    w = word_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.rho        <= w.rho;
                    in_ch.theta      <= w.theta;
                    in_ch.line_valid <= w.line_valid;
                    in_ch.frame_end  <= w.frame_end;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // one long hold-off at the first result after 40 words taken, so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && out_ch.valid && words_taken >= 40)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        lane_avg_t e;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (lane_avg_q.size() == 0)
                begin
                    $error("unexpected lane word, side %0d", out_ch.side);
                    errors++;
                end
                else
                begin
                    e = lane_avg_q.pop_front();
                    if (out_ch.side !== e.side)
                    begin
                        $error("side: expected %0d, got %0d", e.side, out_ch.side);
                        errors++;
                    end
                    if (out_ch.found !== e.found)
                    begin
                        $error("found: expected %0d, got %0d", e.found, out_ch.found);
                        errors++;
                    end
                    if (out_ch.avg_x1 !== e.x1)
                    begin
                        $error("avg_x1: expected %0d, got %0d", e.x1, out_ch.avg_x1);
                        errors++;
                    end
                    if (out_ch.avg_y1 !== e.y1)
                    begin
                        $error("avg_y1: expected %0d, got %0d", e.y1, out_ch.avg_y1);
                        errors++;
                    end
                    if (out_ch.avg_x2 !== e.x2)
                    begin
                        $error("avg_x2: expected %0d, got %0d", e.x2, out_ch.avg_x2);
                        errors++;
                    end
                    if (out_ch.avg_y2 !== e.y2)
                    begin
                        $error("avg_y2: expected %0d, got %0d", e.y2, out_ch.avg_y2);
                        errors++;
                    end
                    if (out_ch.line_count !== e.line_count)
                    begin
                        $error("line_count: expected %0d, got %0d",
                               e.line_count, out_ch.line_count);
                        errors++;
                    end
                    if (out_ch.overflow !== e.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", e.overflow, out_ch.overflow);
                        errors++;
                    end
                    if (out_ch.last_result !== e.last_result)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               e.last_result, out_ch.last_result);
                        errors++;
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input hlca_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            hlca_pkg::CFG_HALF_LENGTH: seg_half = val[11:0];
            hlca_pkg::CFG_LEFT_LOW:    lo_left  = longint'(signed'(val));
            hlca_pkg::CFG_LEFT_HIGH:   hi_left  = longint'(signed'(val));
            hlca_pkg::CFG_RIGHT_LOW:   lo_right = longint'(signed'(val));
            hlca_pkg::CFG_RIGHT_HIGH:  hi_right = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic push_word(input int rho, input int theta, input bit lv, input bit fe);
        line_word_t w;
        w.rho        = rho[16:0];
        w.theta      = theta[15:0];
        w.line_valid = lv;
        w.frame_end  = fe;
        word_q.insert(word_q.size(), w);
    endtask

    function automatic int pick_theta();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(18500, 20800);
            1:       return $urandom_range(46000, 52500);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // frames of random length, half the lines near the window angles, some noise and open frames
    task automatic queue_frames(input int n_lines);
        int made;
        int len;
        made = 0;
        while (made < n_lines)
        begin
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_word($urandom_range(0, 131071), $urandom_range(0, 65535), 0, 0);
                push_word($urandom_range(0, 131071), pick_theta(), 1,
                          (i == len - 1) && $urandom_range(0, 1));
                made++;
            end
            if (len == 0 || !word_q[$].frame_end)
                if ($urandom_range(0, 7) != 0)
                    push_word($urandom_range(0, 131071), $urandom_range(0, 65535), 0, 1);
        end
        push_word(0, 0, 0, 1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (word_q.size() != 0 || in_ch.valid || lane_avg_q.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        errors         = 0;
        words_taken    = 0;
        cycles         = 0;
        send_idle_pct  = 32;
        recv_stall_pct = 59;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        seg_half = 1500;
        lo_left  = -192;
        hi_left  = -166;
        lo_right = 205;
        hi_right = 340;
        for (int k = 0; k < 4; k++)
        begin
            left_sum[k]  = 0;
            right_sum[k] = 0;
        end
        left_n    = 0;
        right_n   = 0;
        left_ovf  = 1'b0;
        right_ovf = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: left, right, vertical, flat, empty frame, noise, rho extremes
        push_word(0, LEFT_THETA, 1, 1);
        push_word(65535, RIGHT_THETA, 1, 0);
        push_word(-65536, RIGHT_THETA, 1, 0);
        push_word(0, 0, 0, 1);
        push_word(-65536, 0, 1, 0);
        push_word(100, 32768, 1, 0);
        push_word(65535, 65535, 1, 1);
        push_word(0, 0, 0, 1);
        push_word(12345, LEFT_THETA, 0, 0);
        push_word(-65536, LEFT_THETA, 1, 0);
        push_word(65535, LEFT_THETA, 1, 0);
        push_word(-1, RIGHT_THETA, 1, 0);
        push_word(0, 0, 0, 1);
        // fill the left count past saturation
        for (int i = 0; i < MAX_LINES + 6; i++)
            push_word($urandom_range(0, 4095) - 2048, LEFT_THETA, 1, 0);
        push_word(0, RIGHT_THETA, 1, 1);
        queue_frames(120);
        wait_drained();

        // left window open wide: it takes the right-slope lines too
        write_reg(hlca_pkg::CFG_HALF_LENGTH, 12'd4095);
        write_reg(hlca_pkg::CFG_LEFT_LOW, 16'h8000);
        write_reg(hlca_pkg::CFG_LEFT_HIGH, 16'h7FFF);
        queue_frames(120);
        wait_drained();

        // swap idle pattern; zero length collapses every segment to a point, so no window takes it
        send_idle_pct  = 59;
        recv_stall_pct = 32;
        write_reg(hlca_pkg::CFG_HALF_LENGTH, 12'd0);
        queue_frames(60);
        wait_drained();

        // inverted left window, right window open wide
        write_reg(hlca_pkg::CFG_HALF_LENGTH, 12'd700);
        write_reg(hlca_pkg::CFG_LEFT_LOW, 16'd100);
        write_reg(hlca_pkg::CFG_LEFT_HIGH, -16'sd100);
        write_reg(hlca_pkg::CFG_RIGHT_LOW, 16'h8000);
        write_reg(hlca_pkg::CFG_RIGHT_HIGH, 16'h7FFF);
        queue_frames(120);
        wait_drained();

        // back to the reset windows, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(hlca_pkg::CFG_HALF_LENGTH, 12'd1500);
        write_reg(hlca_pkg::CFG_LEFT_LOW, -16'sd192);
        write_reg(hlca_pkg::CFG_LEFT_HIGH, -16'sd166);
        write_reg(hlca_pkg::CFG_RIGHT_LOW, 16'sd205);
        write_reg(hlca_pkg::CFG_RIGHT_HIGH, 16'sd340);
        queue_frames(100);
        wait_drained();

        repeat (200) @(posedge clk);
        if (errors == 0 && lane_avg_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hlca_pkg.sv
hdl/hlca_if.sv
hdl/hough_lane_classify_average_top.sv
hdl/hlca_check.sv
tb/sv/tb_hough_lane_classify_average_top.sv
